// ----- hdl/scp_pkg.sv -----
package scp_pkg;

  // Field widths
  localparam int AngleW = 20;
  localparam int ValueW = 18;

  // Working format: unsigned magnitudes with WFrac fraction bits
  localparam int WFrac = 28;

  // Reduced angle magnitude, at most pi/2 (< 2^29)
  localparam int UW   = 29;
  // u*u >> 28, at most about 0.66e9
  localparam int X2W  = 30;
  // Horner terms
  localparam int AW   = 22;
  localparam int BW   = 26;
  localparam int PW   = 29;
  // u*p >> 28
  localparam int MW   = 30;

  // Q.28 constants, rounded to nearest
  localparam longint KPi     = 64'sd843314857;
  localparam longint KHalfPi = 64'sd421657428;
  localparam longint KTwoPi  = 64'sd1686629713;

  localparam logic [15:0] KInv5040 = 16'd53261;
  localparam logic [21:0] KInv120  = 22'd2236962;
  localparam logic [25:0] KInv6    = 26'd44739243;
  localparam logic [28:0] KOne     = 29'h1000_0000;

  // pi/2 as a magnitude
  localparam logic [UW-1:0] HalfPiMag = 29'd421657428;

  typedef struct packed {
    logic          neg;
    logic [UW-1:0] mag;
  } red_t;

endpackage

// ----- hdl/sine_cosine_polynomial.sv -----
// Fixed-point sine/cosine, seventh-order odd polynomial.
// Input channel: in_valid_i / in_stall_o with func_i (0 sine, 1 cosine) and
// angle_i in radians (signed, ANGLE_FRAC_BITS fraction bits). A transfer
// happens on a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with value_o (signed,
// OUT_FRAC_BITS fraction bits, saturated to +-1.0).
// Pipeline: 10 register stages.
// 4 stages of range reduction (offset, wrap, fold, saturate/abs) then 6 of
// polynomial evaluation (square, three Horner steps, final multiply, round).
// Throughput: one item per cycle while out_stall_i is low; each stage holds
// at most one multiply.
// Every stage loads when it is empty or the stage after it moves, so a
// stall on the output only holds items that are behind a full stage;
// bubbles ahead of the stall still fill, and in_stall_o rises only once
// the pipe is full. No item is dropped or repeated.
// Reset clears all valid bits; the data registers are not reset.
module sine_cosine_polynomial #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic signed [scp_pkg::AngleW-1:0] angle_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [scp_pkg::ValueW-1:0] value_o
);
  import scp_pkg::*;

  localparam int Lim = 1 << OUT_FRAC_BITS;
  localparam int PLim = (Lim < 131071) ? Lim : 131071;
  localparam int NLim = (Lim < 131072) ? Lim : 131072;
  localparam logic signed [ValueW-1:0] VMax = ValueW'(PLim);
  localparam logic signed [ValueW-1:0] VMin = ValueW'(-NLim);

  logic red_valid;
  logic red_stall;
  red_t red;

  scp_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .angle_i    (angle_i),
    .out_valid_o(red_valid),
    .out_stall_i(red_stall),
    .red_o      (red)
  );

  scp_poly #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_poly (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (red_valid),
    .in_stall_o (red_stall),
    .red_i      (red),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o)
  );

  // An empty output stage lets the whole chain move
  a_no_stall_when_out_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o
  ) else $error("input stalled while output stage empty");

  // Reduced angle never exceeds pi/2
  a_reduced_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    red_valid |-> (red.mag <= HalfPiMag)
  ) else $error("reduced angle beyond pi/2");

  // Result within the saturation limits
  a_value_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (value_o <= VMax) && (value_o >= VMin)
  ) else $error("result beyond +-1.0");

endmodule

// ----- hdl/scp_reduce.sv -----
module scp_reduce #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic signed [scp_pkg::AngleW-1:0] angle_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output scp_pkg::red_t              red_o
);
  import scp_pkg::*;

  localparam int NStg  = 4;
  localparam int Shift = WFrac - ANGLE_FRAC_BITS;
  localparam int SpanW = (AngleW + Shift > 33) ? (AngleW + Shift) : 33;
  localparam int XW    = SpanW + 2;

  localparam logic signed [XW-1:0] PiX      = XW'(KPi);
  localparam logic signed [XW-1:0] NegPiX   = XW'(-KPi);
  localparam logic signed [XW-1:0] HalfPiX  = XW'(KHalfPi);
  localparam logic signed [XW-1:0] NegHpX   = XW'(-KHalfPi);
  localparam logic signed [XW-1:0] TwoPiX   = XW'(KTwoPi);
  localparam logic signed [XW-1:0] FourPiX  = XW'(2 * KTwoPi);
  localparam logic signed [XW-1:0] ThrPiX   = XW'(KPi + KTwoPi);
  localparam logic signed [XW-1:0] NegThrPi = XW'(-(KPi + KTwoPi));
  localparam logic signed [XW-1:0] OneHpPiX = XW'(KPi + KHalfPi);

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] ld;

  logic signed [XW-1:0] x_d, x_q;
  logic signed [XW-1:0] w_d, w_q;
  logic signed [XW-1:0] f_d, f_q;
  red_t                 red_d, red_q;

  // A stage loads when it is empty or its successor loads too
  always_comb begin
    ld[NStg-1] = !vld_q[NStg-1] || !out_stall_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  always_comb begin
    x_d = (XW'(angle_i) <<< Shift) + (func_i ? HalfPiX : '0);
  end

  // Both wrap directions resolved at once; at most two steps of 2*pi
  always_comb begin
    priority if (x_q > ThrPiX) begin
      w_d = x_q - FourPiX;
    end else if (x_q > PiX) begin
      w_d = x_q - TwoPiX;
    end else if (x_q < NegThrPi) begin
      w_d = x_q + FourPiX;
    end else if (x_q < NegPiX) begin
      w_d = x_q + TwoPiX;
    end else begin
      w_d = x_q;
    end
  end

  // Far above pi/2 both reflections apply: -pi - (pi - w)
  always_comb begin
    priority if (w_q > OneHpPiX) begin
      f_d = w_q - TwoPiX;
    end else if (w_q > HalfPiX) begin
      f_d = PiX - w_q;
    end else if (w_q < NegHpX) begin
      f_d = NegPiX - w_q;
    end else begin
      f_d = w_q;
    end
  end

  // Saturate to +-pi/2 and split into sign and magnitude
  always_comb begin
    red_d.neg = f_q < 0;
    priority if (f_q > HalfPiX) begin
      red_d.mag = HalfPiMag;
    end else if (f_q < NegHpX) begin
      red_d.mag = HalfPiMag;
    end else if (f_q < 0) begin
      red_d.mag = UW'(-f_q);
    end else begin
      red_d.mag = UW'(f_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      x_q <= x_d;
    end
    if (ld[1]) begin
      w_q <= w_d;
    end
    if (ld[2]) begin
      f_q <= f_d;
    end
    if (ld[3]) begin
      red_q <= red_d;
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = vld_q[NStg-1];
  assign red_o       = red_q;

endmodule

// ----- hdl/scp_poly.sv -----
module scp_poly #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  scp_pkg::red_t                     red_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [scp_pkg::ValueW-1:0] value_o
);
  import scp_pkg::*;

  localparam int NStg = 6;
  localparam int RSh  = WFrac - OUT_FRAC_BITS;
  localparam int RW   = MW + 1;
  localparam logic [RW-1:0] Rnd  = RW'(1) << (RSh - 1);
  localparam int Lim  = 1 << OUT_FRAC_BITS;
  localparam int PMax = (Lim < 131071) ? Lim : 131071;
  localparam int NMax = (Lim < 131072) ? Lim : 131072;
  localparam logic [RW-1:0] PMaxR = RW'(PMax);
  localparam logic [RW-1:0] NMaxR = RW'(NMax);

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] ld;

  // stage 1: square
  logic [2*UW-1:0]     sq_full;
  logic [X2W-1:0]      sq1_q;
  logic [UW-1:0]       u1_q;
  logic                n1_q;
  // stage 2: a
  logic [X2W+15:0]     pa_full;
  logic [AW-1:0]       a2_d, a2_q;
  logic [X2W-1:0]      sq2_q;
  logic [UW-1:0]       u2_q;
  logic                n2_q;
  // stage 3: b
  logic [X2W+AW-1:0]   pb_full;
  logic [BW-1:0]       b3_d, b3_q;
  logic [X2W-1:0]      sq3_q;
  logic [UW-1:0]       u3_q;
  logic                n3_q;
  // stage 4: p
  logic [X2W+BW-1:0]   pp_full;
  logic [PW-1:0]       p4_d, p4_q;
  logic [UW-1:0]       u4_q;
  logic                n4_q;
  // stage 5: m
  logic [UW+PW-1:0]    pm_full;
  logic [MW-1:0]       m5_q;
  logic                n5_q;
  // stage 6: round, clamp, sign
  logic [RW-1:0]       rsum;
  logic [RW-1:0]       rmag;
  logic [RW-1:0]       cmag;
  logic signed [ValueW-1:0] value_d, value_q;

  always_comb begin
    ld[NStg-1] = !vld_q[NStg-1] || !out_stall_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  always_comb begin
    sq_full = (2*UW)'(red_i.mag) * (2*UW)'(red_i.mag);
    pa_full = (X2W+16)'(sq1_q) * (X2W+16)'(KInv5040);
    a2_d    = KInv120 - AW'(pa_full[WFrac +: (X2W+16-WFrac)]);
    pb_full = (X2W+AW)'(sq2_q) * (X2W+AW)'(a2_q);
    b3_d    = KInv6 - BW'(pb_full[WFrac +: (X2W+AW-WFrac)]);
    pp_full = (X2W+BW)'(sq3_q) * (X2W+BW)'(b3_q);
    p4_d    = KOne - PW'(pp_full[WFrac +: (X2W+BW-WFrac)]);
    pm_full = (UW+PW)'(u4_q) * (UW+PW)'(p4_q);
  end

  // Round half up on the magnitude, then clamp to the output limits
  always_comb begin
    rsum = RW'(m5_q) + Rnd;
    rmag = rsum >> RSh;
    if (n5_q) begin
      cmag    = (rmag > NMaxR) ? NMaxR : rmag;
      value_d = -$signed(ValueW'(cmag));
    end else begin
      cmag    = (rmag > PMaxR) ? PMaxR : rmag;
      value_d = $signed(ValueW'(cmag));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      sq1_q <= sq_full[WFrac +: X2W];
      u1_q  <= red_i.mag;
      n1_q  <= red_i.neg;
    end
    if (ld[1]) begin
      a2_q  <= a2_d;
      sq2_q <= sq1_q;
      u2_q  <= u1_q;
      n2_q  <= n1_q;
    end
    if (ld[2]) begin
      b3_q  <= b3_d;
      sq3_q <= sq2_q;
      u3_q  <= u2_q;
      n3_q  <= n2_q;
    end
    if (ld[3]) begin
      p4_q <= p4_d;
      u4_q <= u3_q;
      n4_q <= n3_q;
    end
    if (ld[4]) begin
      m5_q <= pm_full[WFrac +: MW];
      n5_q <= n4_q;
    end
    if (ld[5]) begin
      value_q <= value_d;
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = vld_q[NStg-1];
  assign value_o     = value_q;

endmodule
